// ----- rtl/pedal_plausibility_filter_macros.svh -----
// ---------------------------------------------------------------------------
// Pedal plausibility filter assertion macros
// Shared concurrent assertion forms for the pedal filter RTL.
// ---------------------------------------------------------------------------
`ifndef PEDAL_PLAUSIBILITY_FILTER_MACROS_SVH
`define PEDAL_PLAUSIBILITY_FILTER_MACROS_SVH

// Check a consequent in the same cycle as its antecedent
`define PPF_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent
`define PPF_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ppf_pkg.sv -----
// ---------------------------------------------------------------------------
// Pedal plausibility filter package
// Widths, constants, register indexes, sequencer states and word types.
// ---------------------------------------------------------------------------
package ppf_pkg;

  localparam int ADC_BITS   = 12;
  localparam int PCT_W      = 15;
  localparam int CNT_W      = 8;
  localparam int ALPHA_W    = 16;
  localparam int CFG_W      = 16;
  localparam int STEP_W     = 4;
  localparam int MUL_DIGITS = ALPHA_W / 2;

  localparam logic [PCT_W-1:0]   FULL_PCT  = 15'd25600;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 16'd32768;
  localparam logic [CNT_W-1:0]   COUNT_MAX = 8'hFF;

  // Last step of the bit-serial divide and of the radix-4 multiply
  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(PCT_W - 1);
  localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(MUL_DIGITS - 1);

  typedef enum logic [2:0] {
    REG_ADC_LOW,
    REG_ADC_HIGH,
    REG_TOLERANCE,
    REG_DEBOUNCE,
    REG_FLOOR,
    REG_CEILING,
    REG_ALPHA,
    REG_RISE
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_LOAD,
    ST_DIV,
    ST_EMA,
    ST_MUL,
    ST_ACC,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [ADC_BITS-1:0] sample_a;
    logic [ADC_BITS-1:0] sample_b;
  } sample_t;

  typedef struct packed {
    logic [PCT_W-1:0] demand_percent;
    logic [PCT_W-1:0] filtered_percent;
    logic [PCT_W-1:0] converted_percent;
    logic             plausible;
    logic             contradiction;
    logic             rate_clamped;
  } result_t;

endpackage

// ----- rtl/pedal_plausibility_filter.sv -----
// ---------------------------------------------------------------------------
// Pedal plausibility filter
// Dual-sample pedal check, percent scaling, asymmetric EMA and rise limit.
// ---------------------------------------------------------------------------
// Usage:
//   sample channel (sample_valid/sample_ready/sample) carries one word with
//   two ADC readings of the pedal. result channel (result_valid/
//   result_ready/result) returns exactly one word per sample word.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the eight
//   setup registers; cfg_ready is high outside reset. Write only while idle.
// Sequence:
//   A disagreeing or range-faulted word goes from its check straight to the
//   result. A word between the low and high ADC points runs a 15-step
//   bit-serial divide; a seeded EMA that does not fall runs an 8-step
//   radix-4 multiply for its update. The divide and multiply sequencer
//   handles one word at a time.
// Reset (rst, synchronous): registers go to their defaults, the filter
//   state clears, the EMA is unprimed and no result is pending. Both
//   sample_ready and cfg_ready stay low while rst is high.
// Stall: a finished result waits in the output register while the next
//   sample word is taken and worked on; that word then holds in its last
//   step until the output register frees.
// ---------------------------------------------------------------------------
`include "pedal_plausibility_filter_macros.svh"

module pedal_plausibility_filter (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_valid,
  output logic                 sample_ready,
  input  ppf_pkg::sample_t     sample,
  output logic                 result_valid,
  input  logic                 result_ready,
  output ppf_pkg::result_t     result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  ppf_pkg::reg_index_t  cfg_index,
  input  logic [ppf_pkg::CFG_W-1:0] cfg_data
);

  import ppf_pkg::*;

  // Setup registers
  logic [ADC_BITS-1:0] cfg_low;
  logic [ADC_BITS-1:0] cfg_high;
  logic [ADC_BITS-1:0] cfg_tol;
  logic [CNT_W-1:0]    cfg_debounce;
  logic [ADC_BITS-1:0] cfg_floor;
  logic [ADC_BITS-1:0] cfg_ceil;
  logic [ALPHA_W-1:0]  cfg_alpha;
  logic [PCT_W-1:0]    cfg_rise;

  // Filter state
  logic [PCT_W-1:0] demand_value;
  logic [PCT_W-1:0] ema_value;
  logic             ema_seeded;
  logic [CNT_W-1:0] disagree_count;
  logic [PCT_W-1:0] unfiltered_value;

  // Sequencer
  state_t state;
  state_t state_next;
  logic   out_load;

  // Working registers
  logic [ADC_BITS-1:0] samp_a;
  logic [ADC_BITS-1:0] samp_b;
  logic [ADC_BITS-1:0] x_off;
  logic [ADC_BITS-1:0] den;
  logic [ADC_BITS-1:0] rem;
  logic [PCT_W-1:0]    quo;
  logic [STEP_W-1:0]   step;
  logic [ALPHA_W-1:0]  alpha_sh;
  logic [PCT_W:0]      m1;
  logic [PCT_W+2:0]    m3;
  logic [PCT_W:0]      acc;
  logic                run_rate;
  logic                plaus_r;
  logic                contra_r;

  // Combinational datapath
  logic [ADC_BITS:0]   sum_ab;
  logic [ADC_BITS-1:0] avg;
  logic [ADC_BITS-1:0] diff;
  logic                disagree;
  logic                range_fault;
  logic                at_low;
  logic                at_high;
  logic [CNT_W-1:0]    count_inc;
  logic                contra_now;
  logic [ADC_BITS+6:0] x100;
  logic [ADC_BITS:0]   trial;
  logic [ADC_BITS:0]   trial_sub;
  logic                trial_ge;
  logic [PCT_W-1:0]    pct_gap;
  logic [PCT_W:0]      m1_new;
  logic [ALPHA_W-1:0]  alpha_sat;
  logic [PCT_W+2:0]    addend;
  logic [PCT_W+2:0]    mul_sum;
  logic [PCT_W-1:0]    rise_gap;
  logic                clamp;
  logic [PCT_W-1:0]    demand_fin;

  // Configuration writes
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_low      <= '0;
      cfg_high     <= 12'd4095;
      cfg_tol      <= 12'd100;
      cfg_debounce <= 8'd3;
      cfg_floor    <= '0;
      cfg_ceil     <= 12'd4095;
      cfg_alpha    <= 16'd8192;
      cfg_rise     <= 15'd512;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ADC_LOW:   cfg_low      <= cfg_data[ADC_BITS-1:0];
        REG_ADC_HIGH:  cfg_high     <= cfg_data[ADC_BITS-1:0];
        REG_TOLERANCE: cfg_tol      <= cfg_data[ADC_BITS-1:0];
        REG_DEBOUNCE:  cfg_debounce <= cfg_data[CNT_W-1:0];
        REG_FLOOR:     cfg_floor    <= cfg_data[ADC_BITS-1:0];
        REG_CEILING:   cfg_ceil     <= cfg_data[ADC_BITS-1:0];
        REG_ALPHA:     cfg_alpha    <= cfg_data[ALPHA_W-1:0];
        REG_RISE:      cfg_rise     <= cfg_data[PCT_W-1:0];
      endcase
    end
  end

  // Sample checks: difference, average, range
  assign sum_ab      = {1'b0, samp_a} + {1'b0, samp_b};
  assign avg         = sum_ab[ADC_BITS:1];
  assign diff        = (samp_a >= samp_b) ? (samp_a - samp_b) : (samp_b - samp_a);
  assign disagree    = diff > cfg_tol;
  assign range_fault = (avg < cfg_floor) || (avg > cfg_ceil);
  assign at_low      = avg <= cfg_low;
  assign at_high     = avg >= cfg_high;
  assign count_inc   = (disagree_count == COUNT_MAX) ? disagree_count
                                                     : disagree_count + 1'b1;
  assign contra_now  = count_inc >= cfg_debounce;

  // Offset times 100; the percent numerator is this shifted up by 8
  assign x100 = {1'b0, x_off, 6'b0} + {2'b0, x_off, 5'b0} + {5'b0, x_off, 2'b0};

  // One restoring divide step: remainder shifted, next numerator bit in
  assign trial     = {rem, quo[PCT_W-1]};
  assign trial_ge  = trial >= {1'b0, den};
  assign trial_sub = trial - {1'b0, den};

  // EMA multiply setup: twice the gap so the radix-4 result is the >>15 product
  assign pct_gap   = quo - ema_value;
  assign m1_new    = {pct_gap, 1'b0};
  assign alpha_sat = (cfg_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg_alpha;

  // Radix-4 multiply digit, LSB first, accumulator shifts right each step
  always_comb begin
    unique case (alpha_sh[1:0])
      2'd0: addend = '0;
      2'd1: addend = {2'b0, m1};
      2'd2: addend = {1'b0, m1, 1'b0};
      2'd3: addend = m3;
    endcase
  end
  assign mul_sum = {2'b0, acc} + addend;

  // Rise limit on the demand
  assign rise_gap   = ema_value - demand_value;
  assign clamp      = (ema_value > demand_value) && (rise_gap > cfg_rise);
  assign demand_fin = !run_rate ? demand_value
                    : clamp     ? demand_value + cfg_rise
                                : ema_value;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (sample_valid) state_next = ST_CHECK;
      ST_CHECK: begin
        if (disagree || range_fault) state_next = ST_FIN;
        else if (at_low || at_high)  state_next = ST_EMA;
        else                         state_next = ST_LOAD;
      end
      ST_LOAD:  state_next = ST_DIV;
      ST_DIV:   if (step == DIV_LAST) state_next = ST_EMA;
      ST_EMA:   state_next = (ema_seeded && quo >= ema_value) ? ST_MUL : ST_FIN;
      ST_MUL:   if (step == MUL_LAST) state_next = ST_ACC;
      ST_ACC:   state_next = ST_FIN;
      ST_FIN:   if (out_load) state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    sample_ready = 1'b0;
    out_load     = 1'b0;
    unique case (state)
      ST_IDLE: sample_ready = !rst;
      ST_FIN:  out_load     = !result_valid || result_ready;
      default: ;
    endcase
  end

  // Advance the sequencer and the filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      result_valid     <= 1'b0;
      demand_value     <= '0;
      ema_value        <= '0;
      ema_seeded       <= 1'b0;
      disagree_count   <= '0;
      unfiltered_value <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_CHECK: begin
          if (disagree) begin
            disagree_count <= count_inc;
            if (contra_now) demand_value <= '0;
          end else begin
            disagree_count <= '0;
            if (range_fault) begin
              demand_value     <= '0;
              unfiltered_value <= '0;
              ema_value        <= '0;
              ema_seeded       <= 1'b0;
            end
          end
        end
        ST_EMA: begin
          unfiltered_value <= quo;
          ema_seeded       <= 1'b1;
          if (!(ema_seeded && quo >= ema_value)) ema_value <= quo;
        end
        ST_ACC:  ema_value <= ema_value + acc[PCT_W-1:0];
        ST_FIN:  if (out_load) demand_value <= demand_fin;
        default: ;
      endcase
    end
  end

  // Working registers and result word
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (sample_valid) begin
          samp_a <= sample.sample_a;
          samp_b <= sample.sample_b;
        end
      end
      ST_CHECK: begin
        x_off    <= avg - cfg_low;
        den      <= cfg_high - cfg_low;
        quo      <= at_low ? '0 : FULL_PCT;
        run_rate <= !disagree && !range_fault;
        plaus_r  <= disagree ? !contra_now : !range_fault;
        contra_r <= disagree && contra_now;
      end
      ST_LOAD: begin
        rem  <= x100[ADC_BITS+6:7];
        quo  <= {x100[6:0], 8'b0};
        step <= '0;
      end
      ST_DIV: begin
        rem  <= trial_ge ? trial_sub[ADC_BITS-1:0] : trial[ADC_BITS-1:0];
        quo  <= {quo[PCT_W-2:0], trial_ge};
        step <= step + 1'b1;
      end
      ST_EMA: begin
        m1       <= m1_new;
        m3       <= {2'b0, m1_new} + {1'b0, m1_new, 1'b0};
        alpha_sh <= alpha_sat;
        acc      <= '0;
        step     <= '0;
      end
      ST_MUL: begin
        acc      <= mul_sum[PCT_W+2:2];
        alpha_sh <= {2'b0, alpha_sh[ALPHA_W-1:2]};
        step     <= step + 1'b1;
      end
      ST_FIN: begin
        if (out_load) begin
          result.demand_percent    <= demand_fin;
          result.filtered_percent  <= ema_value;
          result.converted_percent <= unfiltered_value;
          result.plausible         <= plaus_r;
          result.contradiction     <= contra_r;
          result.rate_clamped      <= run_rate && clamp;
        end
      end
      default: ;
    endcase
  end

  // Checks
  `PPF_ASSERT_NEXT(a_one_word, clk, rst, sample_valid && sample_ready, !sample_ready,
    "second word taken while one is in flight")
  `PPF_ASSERT_NOW(a_div_rem, clk, rst, state == ST_DIV, rem < den,
    "divide remainder out of range")
  `PPF_ASSERT_NOW(a_mul_acc, clk, rst, state == ST_MUL, (acc < m1) || (acc == '0),
    "multiply accumulator overgrown")
  `PPF_ASSERT_NOW(a_clamp_flags, clk, rst, result_valid && result.rate_clamped,
    result.plausible && !result.contradiction, "clamp flagged on a faulted word")

endmodule

// ----- test/pedal_plausibility_filter_tb.sv -----
// ---------------------------------------------------------------------------
// Pedal plausibility filter testbench
// Drives sample words through the valid/ready channel with random gaps and
// checks every result word against its typed-in value or an in-bench model
// of the filter: sample agreement and debounce, range faults, percent
// scaling, the asymmetric EMA and the rise limit. A directed table comes
// first, then randomized phases, each under its own register setup.
// ---------------------------------------------------------------------------
module pedal_plausibility_filter_tb;
  import ppf_pkg::*;

  localparam int ALL_LOW_PHASE  = 1;
  localparam int ALL_HIGH_PHASE = 2;
  localparam int SPLIT_PHASE    = 3;
  localparam int PHASE_COUNT    = 12;
  localparam int ROW_COUNT      = 37;

  localparam logic [CFG_W-1:0] RESET_SETTING [0:7] = '{
    16'd0, 16'd4095, 16'd100, 16'd3, 16'd0, 16'd4095, 16'd8192, 16'd512
  };
  localparam result_t NO_WORD = '0;

  typedef struct {
    logic                cfg_write;
    reg_index_t          reg_sel;
    logic [CFG_W-1:0]    reg_value;
    logic [ADC_BITS-1:0] a;
    logic [ADC_BITS-1:0] b;
    logic                typed;
    result_t             want;
  } bench_row_t;

  // Directed table: register writes and sample words, some with known results typed in
  bench_row_t bench_rows [ROW_COUNT] = '{
    '{1'b0, REG_ADC_LOW, 16'd0, 12'd0, 12'd0, 1'b1,
      '{15'd0, 15'd0, 15'd0, 1'b1, 1'b0, 1'b0}},
    '{1'b0, REG_ADC_LOW, 16'd0, 12'd4095, 12'd4095, 1'b1,
      '{15'd512, 15'd6400, 15'd25600, 1'b1, 1'b0, 1'b1}},
    '{1'b0, REG_ADC_LOW, 16'd0, 12'd4095, 12'd0, 1'b1,
      '{15'd512, 15'd6400, 15'd25600, 1'b1, 1'b0, 1'b0}},
    '{1'b0, REG_ADC_LOW, 16'd0, 12'd4095, 12'd0, 1'b1,
      '{15'd512, 15'd6400, 15'd25600, 1'b1, 1'b0, 1'b0}},
    '{1'b0, REG_ADC_LOW, 16'd0, 12'd4095, 12'd0, 1'b1,
      '{15'd0, 15'd6400, 15'd25600, 1'b0, 1'b1, 1'b0}},
    '{1'b0, REG_ADC_LOW, 16'd0, 12'd0, 12'd4095, 1'b1,
      '{15'd0, 15'd6400, 15'd25600, 1'b0, 1'b1, 1'b0}},
    '{1'b0, REG_ADC_LOW, 16'd0, 12'd2048, 12'd2048, 1'b0, NO_WORD},
    '{1'b0, REG_ADC_LOW, 16'd0, 12'd100, 12'd0, 1'b0, NO_WORD},
    '{1'b0, REG_ADC_LOW, 16'd0, 12'd101, 12'd0, 1'b0, NO_WORD},
    '{1'b1, REG_FLOOR, 16'd1000, 12'd0, 12'd0, 1'b0, NO_WORD},
    '{1'b1, REG_CEILING, 16'd3000, 12'd0, 12'd0, 1'b0, NO_WORD},
    '{1'b0, REG_ADC_LOW, 16'd0, 12'd999, 12'd999, 1'b1, NO_WORD},
    '{1'b0, REG_ADC_LOW, 16'd0, 12'd3001, 12'd3001, 1'b1, NO_WORD},
    '{1'b0, REG_ADC_LOW, 16'd0, 12'd1000, 12'd1000, 1'b1,
      '{15'd512, 15'd6251, 15'd6251, 1'b1, 1'b0, 1'b1}},
    '{1'b0, REG_ADC_LOW, 16'd0, 12'd3000, 12'd3000, 1'b0, NO_WORD},
    '{1'b1, REG_FLOOR, 16'd0, 12'd0, 12'd0, 1'b0, NO_WORD},
    '{1'b1, REG_CEILING, 16'd4095, 12'd0, 12'd0, 1'b0, NO_WORD},
    '{1'b1, REG_ALPHA, 16'd65535, 12'd0, 12'd0, 1'b0, NO_WORD},
    '{1'b1, REG_RISE, 16'd32767, 12'd0, 12'd0, 1'b0, NO_WORD},
    '{1'b1, REG_DEBOUNCE, 16'd0, 12'd0, 12'd0, 1'b0, NO_WORD},
    '{1'b0, REG_ADC_LOW, 16'd0, 12'd4095, 12'd4095, 1'b1,
      '{15'd25600, 15'd25600, 15'd25600, 1'b1, 1'b0, 1'b0}},
    '{1'b0, REG_ADC_LOW, 16'd0, 12'd0, 12'd4095, 1'b1,
      '{15'd0, 15'd25600, 15'd25600, 1'b0, 1'b1, 1'b0}},
    '{1'b0, REG_ADC_LOW, 16'd0, 12'd4095, 12'd4095, 1'b1,
      '{15'd25600, 15'd25600, 15'd25600, 1'b1, 1'b0, 1'b0}},
    '{1'b1, REG_ADC_LOW, 16'd1000, 12'd0, 12'd0, 1'b0, NO_WORD},
    '{1'b1, REG_ADC_HIGH, 16'd1000, 12'd0, 12'd0, 1'b0, NO_WORD},
    '{1'b1, REG_ALPHA, 16'd0, 12'd0, 12'd0, 1'b0, NO_WORD},
    '{1'b1, REG_RISE, 16'd0, 12'd0, 12'd0, 1'b0, NO_WORD},
    '{1'b0, REG_ADC_LOW, 16'd0, 12'd1000, 12'd1000, 1'b1,
      '{15'd0, 15'd0, 15'd0, 1'b1, 1'b0, 1'b0}},
    '{1'b0, REG_ADC_LOW, 16'd0, 12'd1001, 12'd1001, 1'b1,
      '{15'd0, 15'd0, 15'd25600, 1'b1, 1'b0, 1'b0}},
    '{1'b1, REG_ALPHA, 16'd32768, 12'd0, 12'd0, 1'b0, NO_WORD},
    '{1'b0, REG_ADC_LOW, 16'd0, 12'd4095, 12'd4095, 1'b1,
      '{15'd0, 15'd25600, 15'd25600, 1'b1, 1'b0, 1'b1}},
    '{1'b1, REG_ADC_LOW, 16'd4095, 12'd0, 12'd0, 1'b0, NO_WORD},
    '{1'b1, REG_ADC_HIGH, 16'd0, 12'd0, 12'd0, 1'b0, NO_WORD},
    '{1'b0, REG_ADC_LOW, 16'd0, 12'd4095, 12'd4095, 1'b1,
      '{15'd0, 15'd0, 15'd0, 1'b1, 1'b0, 1'b0}},
    '{1'b1, REG_TOLERANCE, 16'd0, 12'd0, 12'd0, 1'b0, NO_WORD},
    '{1'b0, REG_ADC_LOW, 16'd0, 12'd1, 12'd0, 1'b1,
      '{15'd0, 15'd0, 15'd0, 1'b0, 1'b1, 1'b0}},
    '{1'b0, REG_ADC_LOW, 16'd0, 12'd7, 12'd7, 1'b1,
      '{15'd0, 15'd0, 15'd0, 1'b1, 1'b0, 1'b0}}
  };

  logic             clk;
  logic             rst;
  logic             sample_valid;
  logic             sample_ready;
  sample_t          sample;
  logic             result_valid;
  logic             result_ready;
  result_t          result;
  logic             cfg_valid;
  logic             cfg_ready;
  reg_index_t       cfg_index;
  logic [CFG_W-1:0] cfg_data;

  // Filter model: register copies and running state
  logic [ADC_BITS-1:0] cfg_low;
  logic [ADC_BITS-1:0] cfg_high;
  logic [ADC_BITS-1:0] cfg_tol;
  logic [CNT_W-1:0]    cfg_debounce;
  logic [ADC_BITS-1:0] cfg_floor;
  logic [ADC_BITS-1:0] cfg_ceil;
  logic [ALPHA_W-1:0]  cfg_alpha;
  logic [PCT_W-1:0]    cfg_rise;
  logic [PCT_W-1:0]    demand_q;
  logic [PCT_W-1:0]    ema_q;
  logic [PCT_W-1:0]    converted_q;
  logic                ema_seeded;
  logic [CNT_W-1:0]    mismatch_run;

  result_t     filter_words_due [$];
  int          fail_count = 0;
  int unsigned send_mode  = 1;
  int unsigned sent_count = 0;
  int unsigned split_left = 0;
  int          pedal_level = 2048;

  pedal_plausibility_filter DUT (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_800_000;
    $display("pedal_plausibility_filter_tb failed");
    $finish;
  end

  // Mirror a register write into the model, keeping only the field width
  function automatic void apply_setting(reg_index_t idx, logic [CFG_W-1:0] value);
    case (idx)
      REG_ADC_LOW:   cfg_low      = value[ADC_BITS-1:0];
      REG_ADC_HIGH:  cfg_high     = value[ADC_BITS-1:0];
      REG_TOLERANCE: cfg_tol      = value[ADC_BITS-1:0];
      REG_DEBOUNCE:  cfg_debounce = value[CNT_W-1:0];
      REG_FLOOR:     cfg_floor    = value[ADC_BITS-1:0];
      REG_CEILING:   cfg_ceil     = value[ADC_BITS-1:0];
      REG_ALPHA:     cfg_alpha    = value[ALPHA_W-1:0];
      REG_RISE:      cfg_rise     = value[PCT_W-1:0];
      default: ;
    endcase
  endfunction

  // Advance the filter model by one sample word and return its result word
  function automatic result_t pedal_filter_step(sample_t w);
    int unsigned a, b, span, avg, pct, alpha;
    result_t r;
    a = w.sample_a;
    b = w.sample_b;
    span = (a >= b) ? a - b : b - a;
    r = '0;
    r.plausible = 1'b1;
    if (span > cfg_tol) begin
      // disagreement: count up, flag the contradiction at or above the limit
      if (mismatch_run != COUNT_MAX) mismatch_run++;
      if (mismatch_run >= cfg_debounce) begin
        r.contradiction = 1'b1;
        r.plausible = 1'b0;
        demand_q = '0;
      end
    end else begin
      avg = (a + b) >> 1;
      mismatch_run = '0;
      if (avg < cfg_floor || avg > cfg_ceil) begin
        // range fault clears the whole filter
        r.plausible = 1'b0;
        demand_q = '0;
        converted_q = '0;
        ema_q = '0;
        ema_seeded = 1'b0;
      end else begin
        if (avg <= cfg_low) pct = 0;
        else if (avg >= cfg_high) pct = FULL_PCT;
        else pct = (avg - cfg_low) * FULL_PCT / (cfg_high - cfg_low);
        converted_q = PCT_W'(pct);
        // snap down at once, smooth on the way up
        if (!ema_seeded || pct < ema_q) begin
          ema_q = PCT_W'(pct);
          ema_seeded = 1'b1;
        end else begin
          alpha = (cfg_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg_alpha;
          ema_q = ema_q + PCT_W'((alpha * (pct - ema_q)) >> 15);
        end
        if (ema_q > demand_q && ema_q - demand_q > cfg_rise) begin
          demand_q = demand_q + cfg_rise;
          r.rate_clamped = 1'b1;
        end else begin
          demand_q = ema_q;
        end
      end
    end
    r.demand_percent = demand_q;
    r.filtered_percent = ema_q;
    r.converted_percent = converted_q;
    return r;
  endfunction

  function automatic int unsigned draw_wait(int unsigned mode);
    case (mode)
      0: return 0;
      1: return $urandom_range(19, 0);
      default: return ($urandom_range(3, 0) == 0) ? $urandom_range(19, 1) : 0;
    endcase
  endfunction

  // Pick a register value: extremes in the corner phases, else a usable spread
  function automatic logic [CFG_W-1:0] pick_setting(reg_index_t idx, int phase);
    int unsigned width, lo, hi, roll;
    logic [CFG_W-1:0] mask, value;
    width = ADC_BITS;
    lo = 0;
    hi = 4095;
    case (idx)
      REG_ADC_LOW:   hi = 1200;
      REG_ADC_HIGH:  lo = 2500;
      REG_TOLERANCE: hi = 300;
      REG_DEBOUNCE:  begin width = CNT_W; lo = 1; hi = 6; end
      REG_FLOOR:     hi = ($urandom_range(1, 0) != 0) ? 600 : 0;
      REG_CEILING:   lo = 3400;
      REG_ALPHA:     begin width = ALPHA_W; hi = ALPHA_ONE; end
      REG_RISE:      begin width = PCT_W; hi = 4000; end
      default: ;
    endcase
    mask = CFG_W'((32'd1 << width) - 1);
    roll = $urandom_range(7, 0);
    if (phase == ALL_LOW_PHASE || (phase > SPLIT_PHASE && roll == 0)) value = '0;
    else if (phase == ALL_HIGH_PHASE || (phase > SPLIT_PHASE && roll == 1)) value = mask;
    else value = CFG_W'($urandom_range(hi, lo));
    // unused upper bits must be ignored
    if ($urandom_range(1, 0) != 0) value = value | (CFG_W'($urandom) & ~mask);
    return value;
  endfunction

  // Next random sample word: mostly a wandering pedal with agreeing readings,
  // plus runs of disagreement and plain noise
  function automatic sample_t next_pedal_word(bit force_split);
    int unsigned roll, span, base, spread;
    int other;
    sample_t w;
    roll = $urandom_range(99, 0);
    if (split_left != 0) begin
      split_left--;
      force_split = 1'b1;
    end else if (roll < 5) begin
      split_left = $urandom_range(cfg_debounce + 2, 1);
    end
    if (force_split && cfg_tol != 12'hFFF) begin
      span = $urandom_range(4095, cfg_tol + 1);
      base = $urandom_range(4095 - span, 0);
      w.sample_a = ADC_BITS'(roll[0] ? base : base + span);
      w.sample_b = ADC_BITS'(roll[0] ? base + span : base);
    end else if (roll < 20) begin
      w.sample_a = ADC_BITS'($urandom);
      w.sample_b = ADC_BITS'($urandom);
    end else begin
      if (roll < 26) pedal_level = $urandom_range(4095, 0);
      else pedal_level = pedal_level + int'($urandom_range(400, 0)) - 200;
      if (pedal_level > 4095) pedal_level = 4095;
      else if (pedal_level < 0) pedal_level = 0;
      spread = (roll > 94) ? cfg_tol : $urandom_range(cfg_tol, 0);
      other = roll[0] ? pedal_level + int'(spread) : pedal_level - int'(spread);
      // mirror back into range, then clamp; the gap never grows
      if (other > 4095 || other < 0) other = 2 * pedal_level - other;
      if (other > 4095) other = 4095;
      else if (other < 0) other = 0;
      w.sample_a = ADC_BITS'(pedal_level);
      w.sample_b = ADC_BITS'(other);
    end
    return w;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Offer one sample word after a random gap; queue its expected result
  task automatic send_sample(sample_t word, bit typed, result_t want);
    int unsigned hold;
    result_t predicted;
    hold = draw_wait(send_mode);
    @(negedge clk);
    if (hold != 0) begin
      sample_valid <= 1'b0;
      repeat (hold) @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample <= word;
    do @(posedge clk); while (!sample_ready);
    predicted = pedal_filter_step(word);
    filter_words_due.push_back(typed ? want : predicted);
    sent_count++;
    if (sent_count % 40 == 0) send_mode = $urandom_range(2, 0);
  endtask

  // Drop valid and wait until every result word is back and the block is idle
  task automatic settle_block();
    @(negedge clk);
    sample_valid <= 1'b0;
    while (filter_words_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    apply_setting(idx, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Take result words with random stalls and compare them in order
  initial begin : result_sink
    int unsigned hold, taken, mode;
    result_t got, want;
    result_ready = 1'b0;
    mode = 1;
    taken = 0;
    do @(posedge clk); while (rst);
    forever begin
      hold = draw_wait(mode);
      @(negedge clk);
      if (hold != 0) begin
        result_ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid);
      got = result;
      if (filter_words_due.size() == 0) begin
        $error("result word arrived with nothing expected");
        fail_count++;
      end else begin
        want = filter_words_due.pop_front();
        check_field("demand_percent", want.demand_percent, got.demand_percent);
        check_field("filtered_percent", want.filtered_percent, got.filtered_percent);
        check_field("converted_percent", want.converted_percent, got.converted_percent);
        check_field("plausible", want.plausible, got.plausible);
        check_field("contradiction", want.contradiction, got.contradiction);
        check_field("rate_clamped", want.rate_clamped, got.rate_clamped);
      end
      taken++;
      if (taken % 40 == 0) mode = $urandom_range(2, 0);
    end
  end

  initial begin : stimulus
    reg_index_t idx;
    logic [CFG_W-1:0] value;
    sample_t word;
    int unsigned count;
    rst = 1'b1;
    sample_valid = 1'b0;
    sample = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_ADC_LOW;
    cfg_data = '0;

    // Start the model from the reset state
    idx = idx.first();
    do begin
      apply_setting(idx, RESET_SETTING[idx]);
      idx = idx.next();
    end while (idx != idx.first());
    demand_q = '0;
    ema_q = '0;
    converted_q = '0;
    ema_seeded = 1'b0;
    mismatch_run = '0;

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Walk the directed table
    foreach (bench_rows[i]) begin
      if (bench_rows[i].cfg_write) begin
        settle_block();
        write_reg(bench_rows[i].reg_sel, bench_rows[i].reg_value);
      end else begin
        word.sample_a = bench_rows[i].a;
        word.sample_b = bench_rows[i].b;
        send_sample(word, bench_rows[i].typed, bench_rows[i].want);
      end
    end

    // Random phases, each under a fresh register setup
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      settle_block();
      idx = idx.first();
      do begin
        if (phase == 0) value = RESET_SETTING[idx];
        else if (phase == SPLIT_PHASE && idx == REG_DEBOUNCE) value = CFG_W'(COUNT_MAX);
        else value = pick_setting(idx, phase);
        write_reg(idx, value);
        idx = idx.next();
      end while (idx != idx.first());
      // the split phase holds disagreement long enough to saturate the count
      count = (phase == SPLIT_PHASE) ? 300 : 90;
      for (int n = 0; n < count; n++) begin
        send_sample(next_pedal_word(phase == SPLIT_PHASE && n < 280), 1'b0, NO_WORD);
      end
    end

    settle_block();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("pedal_plausibility_filter_tb passed");
    end else begin
      $display("pedal_plausibility_filter_tb failed");
    end
    $finish;
  end

endmodule
